// File: hw/rtl/itpc_pkg.sv
// infix to postfix converter: shared types, codes and character helpers
// no dependencies; imported by the stack cell and the top level
`timescale 1ns / 1ps
`default_nettype none

package itpc_pkg;

  // default operator stack depth
  localparam int STACK_DEPTH_DEF = 16;

  // token kinds
  localparam logic [1:0] KIND_DIGIT = 2'd0;
  localparam logic [1:0] KIND_CELL  = 2'd1;
  localparam logic [1:0] KIND_OPER  = 2'd2;
  localparam logic [1:0] KIND_END   = 2'd3;

  // fault codes
  localparam logic [1:0] FAULT_NONE      = 2'd0;
  localparam logic [1:0] FAULT_OVERFLOW  = 2'd1;
  localparam logic [1:0] FAULT_UNMATCHED = 2'd2;

  // character codes
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;

  // stack shift command, same for every cell
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH,
    OP_POP
  } stack_op_t;

  // what a cell reports about its entry
  typedef struct packed {
    logic [7:0] entry;
    logic       opener;
    logic [1:0] prec;
  } cell_stat_t;

  // sequencer phases
  typedef enum logic [2:0] {
    S_IDLE,
    S_PRE,
    S_POPC,
    S_POPO,
    S_FLUSH,
    S_NOTICE
  } phase_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_opener(input logic [7:0] c);
    return (c == CH_LPAREN) || (c == CH_LBRACK) || (c == CH_LBRACE);
  endfunction

  function automatic logic is_closer(input logic [7:0] c);
    return (c == CH_RPAREN) || (c == CH_RBRACK) || (c == CH_RBRACE);
  endfunction

  function automatic logic is_operator(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
  endfunction

  // brackets 0, additive 1, multiplicative 2
  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    p = 2'd0;
    if ((c == CH_PLUS) || (c == CH_MINUS)) begin
      p = 2'd1;
    end else if ((c == CH_STAR) || (c == CH_SLASH)) begin
      p = 2'd2;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/itpc_char_if.sv
// input channel: one expression character per transfer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface itpc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_final;

  modport source (output valid, output char_code, output is_final, input ready);
  modport sink   (input valid, input char_code, input is_final, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/itpc_token_if.sv
// output channel: one postfix token per transfer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface itpc_token_if;
  logic       valid;
  logic       ready;
  logic [1:0] token_kind;
  logic [7:0] first_char;
  logic [7:0] second_char;
  logic       run_last;
  logic       expr_done;
  logic [1:0] fault_code;

  modport source (output valid, output token_kind, output first_char, output second_char,
                  output run_last, output expr_done, output fault_code, input ready);
  modport sink   (input valid, input token_kind, input first_char, input second_char,
                  input run_last, input expr_done, input fault_code, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/itpc_stack_cell.sv
// one entry of the shifting operator stack, with decode of its contents
// depends on itpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module itpc_stack_cell (
  input  wire                    clk,
  input  itpc_pkg::stack_op_t    stack_op,
  input  wire [7:0]              up_data,
  input  wire [7:0]              down_data,
  output itpc_pkg::cell_stat_t   stat
);
  import itpc_pkg::*;

  logic [7:0] entry;

  // push takes the entry above, pop takes the entry below
  always_ff @(posedge clk) begin
    case (stack_op)
      OP_PUSH: entry <= up_data;
      OP_POP:  entry <= down_data;
      default: entry <= entry;
    endcase
  end

  // decode for the sequencer
  always_comb begin
    stat.entry  = entry;
    stat.opener = is_opener(entry);
    stat.prec   = prec_of(entry);
  end

endmodule

`default_nettype wire

// File: hw/rtl/infix_to_postfix_converter_unit.sv
// infix to postfix converter top level: sequencer, stack cell chain, output register
// depends on itpc_pkg, itpc_char_if, itpc_token_if, itpc_stack_cell
`timescale 1ns / 1ps
`default_nettype none

// Converts an infix expression, one character per transfer, to postfix tokens
// using the shunting-yard method. The operator stack is a chain of
// STACK_DEPTH cells that shifts at most one place per cycle, with the top in
// cell 0. A character is accepted in S_IDLE, then decoded in S_PRE. A closer
// or an operator then pops stacked operators one at a time, and a last
// step pops the matching opener, pushes or drops the operator, or finds the
// stack empty. The final character then flushes the stack one entry at a time
// and sends the end marker, and a fault notice is one more step. Each step
// sends at most one token through a single output register, and a stalled
// output holds the sequencer. The next character is accepted once all work
// for the current one is done.
module infix_to_postfix_converter_unit #(
  parameter int STACK_DEPTH = itpc_pkg::STACK_DEPTH_DEF
) (
  input  wire          clk,
  input  wire          rst,
  itpc_char_if.sink    char_in,
  itpc_token_if.source token_out
);
  import itpc_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  // control state
  phase_t          state, state_next;
  logic [CNT_W-1:0] stack_count;
  logic [CNT_W-1:0] opener_count;
  logic            letter_pending;
  logic [7:0]      held_letter;
  logic            emitted;
  logic            out_valid;

  // current item
  logic [7:0] cur_char;
  logic       cur_fin;
  logic [1:0] cur_fault;

  // output payload
  logic [1:0] out_kind;
  logic [7:0] out_first;
  logic [7:0] out_second;
  logic       out_last;
  logic       out_done;
  logic [1:0] out_fault;

  // sequencer outputs
  logic       emit_en;
  logic [1:0] emit_kind;
  logic [7:0] emit_first;
  logic [7:0] emit_second;
  logic       emit_last;
  logic       emit_done;
  stack_op_t  stack_op;
  logic       pend_set;
  logic       pend_clr;
  logic       end_clr;

  logic       go;
  logic       accept;
  logic [1:0] in_fault;
  logic [1:0] cur_prec;
  logic       stack_full;
  logic       stack_empty;
  phase_t     after_phase;

  cell_stat_t stat [STACK_DEPTH];

  // stack cell chain
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [7:0] up_data;
    logic [7:0] down_data;
    if (i == 0) begin : g_top
      assign up_data = cur_char;
    end else begin : g_mid
      assign up_data = stat[i-1].entry;
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign down_data = '0;
    end else begin : g_low
      assign down_data = stat[i+1].entry;
    end
    itpc_stack_cell u_cell (
      .clk       (clk),
      .stack_op  (stack_op),
      .up_data   (up_data),
      .down_data (down_data),
      .stat      (stat[i])
    );
  end

  // handshake and shared conditions
  assign go          = !out_valid || token_out.ready;
  assign char_in.ready = (state == S_IDLE);
  assign accept      = char_in.valid && (state == S_IDLE);
  assign cur_prec    = prec_of(cur_char);
  assign stack_full  = (stack_count == CNT_FULL);
  assign stack_empty = (stack_count == '0);

  // fault of an incoming character, known before any token goes out
  always_comb begin
    in_fault = FAULT_NONE;
    if (!letter_pending) begin
      if (is_opener(char_in.char_code) && stack_full) begin
        in_fault = FAULT_OVERFLOW;
      end else if (is_operator(char_in.char_code) && stack_full &&
                   (stat[0].prec < prec_of(char_in.char_code))) begin
        in_fault = FAULT_OVERFLOW;
      end else if (is_closer(char_in.char_code) && (opener_count == '0)) begin
        in_fault = FAULT_UNMATCHED;
      end
    end
  end

  // where to go once the character itself is handled
  always_comb begin
    if (cur_fin) begin
      after_phase = S_FLUSH;
    end else if ((cur_fault != FAULT_NONE) && !emitted) begin
      after_phase = S_NOTICE;
    end else begin
      after_phase = S_IDLE;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_PRE;
        end
      end
      S_PRE: begin
        if (go) begin
          if (letter_pending) begin
            state_next = after_phase;
          end else if (is_closer(cur_char)) begin
            state_next = S_POPC;
          end else if (is_operator(cur_char)) begin
            state_next = S_POPO;
          end else begin
            state_next = after_phase;
          end
        end
      end
      S_POPC: begin
        if (go && (stack_empty || stat[0].opener)) begin
          state_next = after_phase;
        end
      end
      S_POPO: begin
        if (go && !(!stack_empty && (stat[0].prec >= cur_prec))) begin
          state_next = after_phase;
        end
      end
      S_FLUSH: begin
        if (go && stack_empty) begin
          state_next = S_IDLE;
        end
      end
      S_NOTICE: begin
        if (go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs: token, stack command, letter bookkeeping
  always_comb begin
    emit_en     = 1'b0;
    emit_kind   = KIND_DIGIT;
    emit_first  = cur_char;
    emit_second = '0;
    emit_last   = 1'b0;
    emit_done   = 1'b0;
    stack_op    = OP_HOLD;
    pend_set    = 1'b0;
    pend_clr    = 1'b0;
    end_clr     = 1'b0;
    case (state)
      S_PRE: begin
        if (go) begin
          if (letter_pending) begin
            emit_en     = 1'b1;
            emit_kind   = KIND_CELL;
            emit_first  = held_letter;
            emit_second = cur_char;
            emit_last   = !cur_fin;
            pend_clr    = 1'b1;
          end else if (is_letter(cur_char)) begin
            if (cur_fin) begin
              emit_en   = 1'b1;
              emit_kind = KIND_CELL;
            end else begin
              pend_set = 1'b1;
            end
          end else if (is_digit(cur_char)) begin
            emit_en   = 1'b1;
            emit_kind = KIND_DIGIT;
            emit_last = !cur_fin;
          end else if (is_opener(cur_char) && !stack_full) begin
            stack_op = OP_PUSH;
          end
        end
      end
      S_POPC: begin
        if (go && !stack_empty) begin
          stack_op = OP_POP;
          if (!stat[0].opener) begin
            emit_en    = 1'b1;
            emit_kind  = KIND_OPER;
            emit_first = stat[0].entry;
            emit_last  = !cur_fin && ((stack_count == CNT_ONE) || stat[1].opener);
          end
        end
      end
      S_POPO: begin
        if (go) begin
          if (!stack_empty && (stat[0].prec >= cur_prec)) begin
            stack_op   = OP_POP;
            emit_en    = 1'b1;
            emit_kind  = KIND_OPER;
            emit_first = stat[0].entry;
            emit_last  = !cur_fin && ((stack_count == CNT_ONE) || (stat[1].prec < cur_prec));
          end else if (!stack_full) begin
            stack_op = OP_PUSH;
          end
        end
      end
      S_FLUSH: begin
        if (go) begin
          if (!stack_empty) begin
            stack_op = OP_POP;
            if (!stat[0].opener) begin
              emit_en    = 1'b1;
              emit_kind  = KIND_OPER;
              emit_first = stat[0].entry;
            end
          end else begin
            emit_en    = 1'b1;
            emit_kind  = KIND_END;
            emit_first = '0;
            emit_last  = 1'b1;
            emit_done  = 1'b1;
            end_clr    = 1'b1;
          end
        end
      end
      S_NOTICE: begin
        if (go) begin
          emit_en   = 1'b1;
          emit_kind = KIND_END;
          emit_last = 1'b1;
        end
      end
      default: begin
        emit_en = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      stack_count    <= '0;
      opener_count   <= '0;
      letter_pending <= 1'b0;
      held_letter    <= '0;
      emitted        <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      // stack depth and opener tally follow the shift command
      case (stack_op)
        OP_PUSH: begin
          stack_count <= stack_count + CNT_ONE;
          if (is_opener(cur_char)) begin
            opener_count <= opener_count + CNT_ONE;
          end
        end
        OP_POP: begin
          stack_count <= stack_count - CNT_ONE;
          if (stat[0].opener) begin
            opener_count <= opener_count - CNT_ONE;
          end
        end
        default: begin
          stack_count <= stack_count;
        end
      endcase
      // letter waiting for its second character
      if (pend_set) begin
        letter_pending <= 1'b1;
        held_letter    <= cur_char;
      end else if (pend_clr || end_clr) begin
        letter_pending <= 1'b0;
        if (end_clr) begin
          held_letter <= '0;
        end
      end
      // whether this item has sent a token yet
      if (accept) begin
        emitted <= 1'b0;
      end else if (emit_en) begin
        emitted <= 1'b1;
      end
      // output register valid
      if (emit_en) begin
        out_valid <= 1'b1;
      end else if (token_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // current item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_char  <= char_in.char_code;
      cur_fin   <= char_in.is_final;
      cur_fault <= in_fault;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (emit_en) begin
      out_kind   <= emit_kind;
      out_first  <= emit_first;
      out_second <= emit_second;
      out_last   <= emit_last;
      out_done   <= emit_done;
      out_fault  <= cur_fault;
    end
  end

  assign token_out.valid       = out_valid;
  assign token_out.token_kind  = out_kind;
  assign token_out.first_char  = out_first;
  assign token_out.second_char = out_second;
  assign token_out.run_last    = out_last;
  assign token_out.expr_done   = out_done;
  assign token_out.fault_code  = out_fault;

  // openers on the stack never outnumber entries
  a_opener_tally: assert property (@(posedge clk) disable iff (rst)
    opener_count <= stack_count)
    else $error("opener tally exceeds stack depth");

  // an end marker goes out with the stack empty and no letter waiting
  a_end_clean: assert property (@(posedge clk) disable iff (rst)
    token_out.valid && token_out.ready && token_out.expr_done |->
      (stack_count == '0) && !letter_pending)
    else $error("state left over after end marker");

  // a kind 3 token without the done flag is a fault notice
  a_notice_fault: assert property (@(posedge clk) disable iff (rst)
    token_out.valid && (token_out.token_kind == KIND_END) && !token_out.expr_done |->
      (token_out.fault_code != FAULT_NONE))
    else $error("fault notice without fault code");

  // an accepted character is decoded next
  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    char_in.valid && char_in.ready |=> (state == S_PRE))
    else $error("accepted character not decoded");

endmodule

`default_nettype wire
